// ----- design/fqtc_pkg.sv -----
// Shared operation codes, status codes and result record for the threshold-count queue.
`default_nettype none

package fqtc_pkg;

  localparam logic [1:0] FUNC_ENQ = 2'd0;
  localparam logic [1:0] FUNC_DEQ = 2'd1;
  localparam logic [1:0] FUNC_CNT = 2'd2;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam int VALUE_W = 32;
  localparam int FIELD_W = 5;

  typedef struct packed {
    logic [1:0]         status;
    logic [VALUE_W-1:0] popped_value;
    logic [FIELD_W-1:0] above_count;
    logic [FIELD_W-1:0] occupancy;
  } fqtc_res_t;

endpackage

`default_nettype wire

// ----- design/fqtc_ram.sv -----
// Ring storage: one write port, one read port with registered read data.
`default_nettype none

module fqtc_ram
  import fqtc_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [ADDR_W-1:0]  waddr,
  input  wire logic [VALUE_W-1:0] wdata,
  input  wire logic               re,
  input  wire logic [ADDR_W-1:0]  raddr,
  output      logic [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/fifo_queue_with_threshold_count.sv -----
// Enqueue, unused codes, a refused enqueue or dequeue and a count on an empty queue go from
// the accept straight to S_HOLD; a dequeue passes S_POP and a count query walks S_SCAN first.
// One item at a time: a new item is taken only once the previous result has left S_HOLD and
// gone valid, and S_HOLD waits while the output is stalled; the count walk reads one stored entry
// per cycle through the single read port of the ring memory.
// Reset (rst, synchronous, active high) clears head, tail, fill level and output valid.
`default_nettype none

module fifo_queue_with_threshold_count
  import fqtc_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // push_value[31:0], threshold[63:32]
  input  wire logic [1:0]  s_axis_tuser,  // func[1:0]
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [47:0] m_axis_tdata,  // popped_value[31:0], above_count[36:32],
                                          // occupancy[41:37], zero[47:42]
  output      logic [1:0]  m_axis_tuser   // status[1:0]
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0]  FULL_LVL = CNT_W'(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(DEPTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_POP, S_SCAN, S_HOLD} state_t;

  state_t              state;
  logic [ADDR_W-1:0]   head;
  logic [ADDR_W-1:0]   tail;
  logic [CNT_W-1:0]    fill;
  logic [CNT_W-1:0]    remain;
  logic [CNT_W-1:0]    cnt;
  logic [ADDR_W-1:0]   pos;
  logic signed [31:0]  thr;
  fqtc_res_t           pend;

  logic                accept;
  logic                out_free;
  logic                is_full;
  logic                is_empty;
  logic                ram_we;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [VALUE_W-1:0]  ram_rdata;
  logic [CNT_W-1:0]    cnt_next;

  function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] p);
    return (p == LAST_POS) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] v);
    logic [CNT_W+FIELD_W-1:0] ext;
    ext = {{FIELD_W{1'b0}}, v};
    return ext[FIELD_W-1:0];
  endfunction

  assign s_axis_tready = (state == S_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign is_full  = (fill == FULL_LVL);
  assign is_empty = (fill == '0);

  always_comb begin
    ram_we    = accept && (s_axis_tuser == FUNC_ENQ) && !is_full;
    ram_re    = 1'b0;
    ram_raddr = head;
    if (accept && !is_empty &&
        ((s_axis_tuser == FUNC_DEQ) || (s_axis_tuser == FUNC_CNT))) begin
      ram_re = 1'b1;
    end else if ((state == S_SCAN) && (remain > CNT_W'(1))) begin
      ram_re    = 1'b1;
      ram_raddr = pos;
    end
  end

  assign cnt_next = cnt + CNT_W'($signed(ram_rdata) > thr);

  fqtc_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (s_axis_tdata[31:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      tail          <= '0;
      fill          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend.status       <= STAT_DONE;
            pend.popped_value <= '0;
            pend.above_count  <= '0;
            pend.occupancy    <= to_field(fill);
            state             <= S_HOLD;
            case (s_axis_tuser)
              FUNC_ENQ: begin
                if (is_full) begin
                  pend.status <= STAT_FULL;
                end else begin
                  tail           <= ring_next(tail);
                  fill           <= fill + 1'b1;
                  pend.occupancy <= to_field(fill + 1'b1);
                end
              end
              FUNC_DEQ: begin
                if (is_empty) begin
                  pend.status <= STAT_EMPTY;
                end else begin
                  head           <= ring_next(head);
                  fill           <= fill - 1'b1;
                  pend.occupancy <= to_field(fill - 1'b1);
                  state          <= S_POP;
                end
              end
              FUNC_CNT: begin
                thr <= $signed(s_axis_tdata[63:32]);
                if (!is_empty) begin
                  remain <= fill;
                  pos    <= ring_next(head);
                  cnt    <= '0;
                  state  <= S_SCAN;
                end
              end
              default: begin
                // unused code: report done, leave the queue alone
              end
            endcase
          end
        end
        S_POP: begin
          pend.popped_value <= ram_rdata;
          state             <= S_HOLD;
        end
        S_SCAN: begin
          // one entry arrives per cycle; stop on the last one held
          if (remain == CNT_W'(1)) begin
            pend.above_count <= to_field(cnt_next);
            state            <= S_HOLD;
          end else begin
            cnt    <= cnt_next;
            remain <= remain - 1'b1;
            pos    <= ring_next(pos);
          end
        end
        S_HOLD: begin
          if (out_free) begin
            m_axis_tdata  <= {6'b0, pend.occupancy, pend.above_count, pend.popped_value};
            m_axis_tuser  <= pend.status;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- verif/fifo_queue_with_threshold_count_test.sv -----
// Stream-level check of the threshold-count queue against a predictor that tracks its own ring.
module fifo_queue_with_threshold_count_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fqtc_pkg::*;

  localparam int RING_DEPTH = 16;
  localparam int RANDOM_OPS = 750;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] push_value;
    logic [31:0] threshold;
    bit          wait_drain;
  } queue_op_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // push_value[31:0], threshold[63:32]
  logic [1:0]  s_axis_tuser = '0;  // func[1:0]
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [47:0] m_axis_tdata;       // popped_value[31:0], above_count[36:32], occupancy[41:37]
  wire  [1:0]  m_axis_tuser;       // status[1:0]

  queue_op_t  op_backlog[$];
  fqtc_res_t  predicted_replies[$];
  queue_op_t  cur_op = '{FUNC_ENQ, 32'd0, 32'd0, 1'b0};

  // predictor copy of the ring
  logic [31:0] ring_mem [RING_DEPTH];
  logic [3:0]  ring_head = '0;
  logic [3:0]  ring_tail = '0;
  logic [4:0]  ring_fill = '0;

  int error_count = 0;
  int replies_seen = 0;
  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_tick = 0;

  fifo_queue_with_threshold_count #(.DEPTH(RING_DEPTH)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  // Advance the ring copy by one accepted operation and record its reply.
  task automatic apply_queue_op(input queue_op_t op);
    fqtc_res_t  r;
    logic [3:0] pos;
    r = '0;
    case (op.func)
      FUNC_ENQ: begin
        if (ring_fill == RING_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          ring_mem[ring_tail] = op.push_value;
          ring_tail++;
          ring_fill++;
        end
      end
      FUNC_DEQ: begin
        if (ring_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.popped_value = ring_mem[ring_head];
          ring_head++;
          ring_fill--;
        end
      end
      FUNC_CNT: begin
        pos = ring_head;
        for (int i = 0; i < ring_fill; i++) begin
          if ($signed(ring_mem[pos]) > $signed(op.threshold)) r.above_count++;
          pos++;
        end
      end
      default: ;
    endcase
    r.occupancy = ring_fill;
    predicted_replies.push_back(r);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void push_op(input logic [1:0] func, input logic [31:0] pv,
                                  input logic [31:0] th, input bit drain = 1'b0);
    queue_op_t op;
    op.func = func;
    op.push_value = pv;
    op.threshold = th;
    op.wait_drain = drain;
    op_backlog.push_back(op);
  endfunction

  // Often small values, besides extremes and random words, so that threshold counts land in the middle.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3, 4: return $urandom;
      default: return 32'(int'($urandom_range(0, 24)) - 12);
    endcase
  endfunction

  always @(posedge clk) begin : driver
    logic offering;
    offering = s_axis_tvalid;
    if (rst) begin
      offering = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_queue_op(cur_op);
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (op_backlog.size() != 0) begin
          if (!op_backlog[0].wait_drain) begin
            cur_op = op_backlog.pop_front();
            offering = 1'b1;
            if (burst_left == 0) begin
              burst_left = $urandom_range(1, 30);
              gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
              burst_left--;
            end
          end else if (predicted_replies.size() == 0) begin
            // hold until every reply is back, then drop the marker
            void'(op_backlog.pop_front());
          end
        end
      end
    end
    s_axis_tvalid <= offering;
    s_axis_tdata  <= {cur_op.threshold, cur_op.push_value};
    s_axis_tuser  <= cur_op.func;
  end

  always @(posedge clk) begin : monitor
    fqtc_res_t want;
    logic      ready;
    ready = 1'b0;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        replies_seen++;
        if (predicted_replies.size() == 0) begin
          $error("transfer with nothing outstanding: tuser %0h tdata %0h",
                 m_axis_tuser, m_axis_tdata);
          error_count++;
        end else begin
          want = predicted_replies.pop_front();
          check_field("status", want.status, m_axis_tuser);
          check_field("popped_value", want.popped_value, m_axis_tdata[31:0]);
          check_field("above_count", want.above_count, m_axis_tdata[36:32]);
          check_field("occupancy", want.occupancy, m_axis_tdata[41:37]);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
      end else if (replies_seen == 300 && !long_hold_done) begin
        // long back-pressure so the input side stalls
        long_hold_done = 1'b1;
        hold_left = 400;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_mode_left = $urandom_range(16, 100);
        end else begin
          rx_mode_left--;
        end
        rx_tick++;
        case (rx_mode)
          0: ready = 1'b1;
          1: ready = ($urandom_range(0, 3) != 0);
          2: ready = ((rx_tick % 4) != 3);
          default: ready = 1'($urandom_range(0, 1));
        endcase
      end
    end
    m_axis_tready <= ready;
  end

  initial begin
    int          made;
    int          seg;
    int          n;
    logic [1:0]  f;

    // directed: empty cases, extreme values and thresholds, unused code
    push_op(FUNC_DEQ, $urandom, $urandom);
    push_op(FUNC_CNT, $urandom, 32'h8000_0000);
    push_op(FUNC_ENQ, 32'h8000_0000, $urandom);
    push_op(FUNC_ENQ, 32'h7fff_ffff, $urandom);
    push_op(FUNC_ENQ, 32'h0000_0000, $urandom);
    push_op(FUNC_ENQ, 32'hffff_ffff, $urandom);
    push_op(FUNC_ENQ, 32'h0000_0001, $urandom);
    push_op(FUNC_CNT, $urandom, 32'h8000_0000);
    push_op(FUNC_CNT, $urandom, 32'h7fff_ffff);
    push_op(FUNC_CNT, $urandom, 32'hffff_ffff);
    push_op(FUNC_CNT, $urandom, 32'h0000_0000);
    push_op(FUNC_CNT, $urandom, 32'h0000_0001);
    push_op(FUNC_UNUSED, $urandom, $urandom);
    repeat (5) push_op(FUNC_DEQ, $urandom, $urandom);
    push_op(FUNC_DEQ, $urandom, $urandom);
    push_op(FUNC_CNT, $urandom, $urandom);
    push_op(FUNC_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    push_op(FUNC_ENQ, 32'd0, 32'd0, 1'b1);

    // random: fill runs, drain runs, mixed runs and noise
    made = 0;
    while (made < RANDOM_OPS) begin
      seg = $urandom_range(0, 9);
      n = $urandom_range(6, 22);
      repeat (n) begin
        if (seg < 3) f = ($urandom_range(0, 4) == 0) ? FUNC_CNT : FUNC_ENQ;
        else if (seg < 6) f = ($urandom_range(0, 4) == 0) ? FUNC_CNT : FUNC_DEQ;
        else if (seg < 9) f = 2'($urandom_range(0, 2));
        else f = 2'($urandom_range(0, 3));
        push_op(f, rand_word(), rand_word());
        if (f != FUNC_UNUSED) made++;
      end
      if ($urandom_range(0, 19) == 0) push_op(FUNC_ENQ, 32'd0, 32'd0, 1'b1);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (op_backlog.size() != 0 || s_axis_tvalid || predicted_replies.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (error_count == 0) begin
      $display("fifo_queue_with_threshold_count_test OK");
    end else begin
      $display("fifo_queue_with_threshold_count_test NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("fifo_queue_with_threshold_count_test NOT OK");
    $finish;
  end

endmodule
